[src/scbpa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the size-class block pool allocator.
// No dependencies.
package scbpa_pkg;

    localparam int POOL_COUNT = 3;
    localparam int POOL_W     = 2;
    localparam int ADDR_W     = 32;
    localparam int BYTES_W    = 13;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 40;
    localparam int STATUS_W   = 3;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STS_ALLOCATED  = 3'd0;
    localparam status_t STS_FALLBACK   = 3'd1;
    localparam status_t STS_RELEASED   = 3'd2;
    localparam status_t STS_NOT_POOLED = 3'd3;
    localparam status_t STS_NULL       = 3'd4;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_BASE_ADDRESS  = 3'd0;
    localparam cfg_idx_t REG_SMALL_BYTES   = 3'd1;
    localparam cfg_idx_t REG_MIDDLE_BYTES  = 3'd2;
    localparam cfg_idx_t REG_LARGE_BYTES   = 3'd3;
    localparam cfg_idx_t REG_SMALL_COUNT   = 3'd4;
    localparam cfg_idx_t REG_MIDDLE_COUNT  = 3'd5;
    localparam cfg_idx_t REG_LARGE_COUNT   = 3'd6;

    localparam logic [ADDR_W-1:0] RST_BASE_ADDRESS = 32'd4096;
    typedef logic [BYTES_W-1:0] bytes_arr_t [POOL_COUNT];
    typedef logic [COUNT_W-1:0] count_arr_t [POOL_COUNT];
    localparam bytes_arr_t RST_BYTES = '{13'd16, 13'd32, 13'd64};
    localparam count_arr_t RST_COUNT = '{8'd20, 8'd100, 8'd20};

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_DECODE = 8'b0000_0100,
        ST_POP    = 8'b0000_1000,
        ST_ADDR   = 8'b0001_0000,
        ST_DIV    = 8'b0010_0000,
        ST_PUSH   = 8'b0100_0000,
        ST_RESULT = 8'b1000_0000
    } state_t;

endpackage

[src/scbpa_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module scbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 384,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/size_class_block_pool_allocator_unit.sv]
`timescale 1ns / 1ps
// Top level of the size-class block pool allocator: config registers, control
// sequencer, free-list link RAM. Depends on scbpa_pkg and scbpa_ram.
//
// Usage:
//   s_ channel: one request per transfer. s_tuser[0] is the kind (0 allocate,
//   1 release), s_tdata carries request_size and release_address.
//   m_ channel: exactly one result per request, in request order. m_tuser is
//   the status, m_tdata carries block_address and pool_index.
//   cfg channel: register writes, always ready; write only while idle.
// Sequence: an allocate runs DECODE, POP, ADDR and RESULT; a release runs DECODE,
//   DIV (the bit-per-cycle divider that turns the pool offset into an index over
//   SPAN_W = 13 + clog2(MAX_BLOCKS+1) quotient bits, 21 by default), PUSH, RESULT.
//   Null releases, fallbacks and addresses outside every pool go DECODE to RESULT.
// Flow: one request is in work at a time; the next one is accepted the
//   cycle after the previous result is loaded.
// Reset and every accepted write to a known register start a clearing pass over
//   the 3 * 2^clog2(MAX_BLOCKS) link RAM entries (384 by default) that rebuilds
//   them, the free-list heads and the pool bases; s_tready stays low meanwhile.
// A stalled m_ channel holds its result; the next request is still accepted and
//   worked on, and waits for the output register before it is shown.
module size_class_block_pool_allocator_unit
    import scbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] request_size, [63:32] release_address
    input  logic [0:0]            s_tuser,   // [0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] block_address, [33:32] pool_index, zeros
    output logic [STATUS_W-1:0]   m_tuser,   // [2:0] status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W    = $clog2(MAX_BLOCKS);
    localparam int ECNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W    = (ECNT_W > COUNT_W) ? ECNT_W : COUNT_W;
    localparam int SPAN_W   = BYTES_W + ECNT_W;
    localparam int LDEPTH   = POOL_COUNT * (1 << IDX_W);
    localparam int LA_W     = $clog2(LDEPTH);
    localparam int DCNT_W   = $clog2(SPAN_W);
    localparam int LINK_W   = IDX_W + 1;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]  base_reg;
    logic [BYTES_W-1:0] bytes_reg [POOL_COUNT];
    logic [COUNT_W-1:0] count_reg [POOL_COUNT];
    logic [ECNT_W-1:0]  eff [POOL_COUNT];

    logic [IDX_W-1:0]   head_reg [POOL_COUNT];
    logic               head_ok_reg [POOL_COUNT];
    logic [SPAN_W-1:0]  span_reg [POOL_COUNT];
    logic [ADDR_W-1:0]  pbase_reg [POOL_COUNT];

    logic [LA_W-1:0]    cnt_reg;
    logic               func_reg;
    logic [ADDR_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  raddr_reg;
    logic [POOL_W-1:0]  pool_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [SPAN_W-1:0]  mul_reg;
    logic [SPAN_W-1:0]  quot_reg;
    logic [BYTES_W-1:0] rem_reg;
    logic [DCNT_W-1:0]  dcnt_reg;

    status_t            res_status_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic               m_tvalid_reg;
    status_t            m_status_reg;
    logic [ADDR_W-1:0]  m_addr_reg;
    logic [POOL_W-1:0]  m_pool_reg;

    logic               cfg_known;
    logic               cfg_wr;
    logic               s_acc;

    logic               alloc_found;
    logic [POOL_W-1:0]  alloc_pool;
    logic               rel_found;
    logic [POOL_W-1:0]  rel_pool;
    logic [ADDR_W-1:0]  rel_off [POOL_COUNT];
    logic [ADDR_W-1:0]  rel_off_sel;

    logic [BYTES_W-1:0] mul_a;
    logic [ECNT_W-1:0]  mul_b;
    logic [SPAN_W-1:0]  mul_res;
    logic [BYTES_W-1:0] div_den;
    logic [BYTES_W:0]   div_sh;
    logic               div_ge;
    logic [BYTES_W:0]   div_diff;
    logic [BYTES_W-1:0] sel_bytes;
    logic [IDX_W-1:0]   sel_head;
    logic               sel_head_ok;
    logic [ADDR_W-1:0]  sel_pbase;

    logic               ram_we;
    logic [LA_W-1:0]    ram_waddr;
    logic [LINK_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [LA_W-1:0]    ram_raddr;
    logic [LINK_W-1:0]  ram_rdata;
    logic [IDX_W-1:0]   clr_idx;

    assign cfg_ready = 1'b1;
    assign cfg_known = (cfg_index <= REG_LARGE_COUNT);
    assign cfg_wr    = cfg_valid && cfg_ready && cfg_known;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;

    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_status_reg;
    assign m_tdata   = {(M_TDATA_W - ADDR_W - POOL_W)'(0), m_pool_reg, m_addr_reg};

    always_comb begin
        for (int p = 0; p < POOL_COUNT; p++) begin
            if (bytes_reg[p] == '0) begin
                eff[p] = '0;
            end else if (CMP_W'(count_reg[p]) > CMP_W'(MAX_BLOCKS)) begin
                eff[p] = ECNT_W'(MAX_BLOCKS);
            end else begin
                eff[p] = ECNT_W'(count_reg[p]);
            end
        end
    end

    always_comb begin
        sel_bytes   = bytes_reg[0];
        sel_head    = head_reg[0];
        sel_head_ok = head_ok_reg[0];
        sel_pbase   = pbase_reg[0];
        rel_off_sel = rel_off[0];
        for (int p = 0; p < POOL_COUNT; p++) begin
            if (pool_reg == POOL_W'(p)) begin
                sel_bytes   = bytes_reg[p];
                sel_head    = head_reg[p];
                sel_head_ok = head_ok_reg[p];
                sel_pbase   = pbase_reg[p];
            end
            if (rel_pool == POOL_W'(p)) begin
                rel_off_sel = rel_off[p];
            end
        end
    end

    // first-fit search: lower pools win
    always_comb begin
        alloc_found = 1'b0;
        alloc_pool  = '0;
        rel_found   = 1'b0;
        rel_pool    = '0;
        for (int p = POOL_COUNT - 1; p >= 0; p--) begin
            rel_off[p] = raddr_reg - pbase_reg[p];
            if (eff[p] != '0 && size_reg <= ADDR_W'(bytes_reg[p]) && head_ok_reg[p]) begin
                alloc_found = 1'b1;
                alloc_pool  = POOL_W'(p);
            end
            if (eff[p] != '0 && rel_off[p] < ADDR_W'(span_reg[p])) begin
                rel_found = 1'b1;
                rel_pool  = POOL_W'(p);
            end
        end
    end

    // one shared multiplier: pool spans during clearing, block offsets otherwise
    always_comb begin
        mul_a = sel_bytes;
        mul_b = ECNT_W'(idx_reg);
        if (state_reg == ST_CLEAR) begin
            mul_a = '0;
            mul_b = '0;
            for (int p = 0; p < POOL_COUNT; p++) begin
                if (cnt_reg == LA_W'(p)) begin
                    mul_a = bytes_reg[p];
                    mul_b = eff[p];
                end
            end
        end
    end
    assign mul_res = SPAN_W'(mul_a) * SPAN_W'(mul_b);

    assign div_den  = sel_bytes;
    assign div_sh   = {rem_reg, quot_reg[SPAN_W-1]};
    assign div_diff = div_sh - {1'b0, div_den};
    assign div_ge   = (div_sh >= {1'b0, div_den});

    assign clr_idx = cnt_reg[IDX_W-1:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = {(clr_idx != '0), IDX_W'(clr_idx - IDX_W'(1))};
        ram_re    = (state_reg == ST_DECODE) && (func_reg == FUNC_ALLOC) && alloc_found;
        ram_raddr = '0;
        for (int p = 0; p < POOL_COUNT; p++) begin
            if (alloc_pool == POOL_W'(p)) begin
                ram_raddr = LA_W'({alloc_pool, head_reg[p]});
            end
        end
        if (state_reg == ST_CLEAR) begin
            ram_we = 1'b1;
        end else if (state_reg == ST_PUSH && rem_reg == '0) begin
            ram_we    = 1'b1;
            ram_waddr = LA_W'({pool_reg, quot_reg[IDX_W-1:0]});
            ram_wdata = {sel_head_ok, sel_head};
        end
    end

    scbpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LDEPTH)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (cnt_reg == LA_W'(LDEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (func_reg == FUNC_ALLOC) begin
                    state_next = alloc_found ? ST_POP : ST_RESULT;
                end else if (raddr_reg != '0 && rel_found) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_POP:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_RESULT;
            ST_DIV: begin
                if (dcnt_reg == '0) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: state_next = ST_RESULT;
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
        if (cfg_wr) begin
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            base_reg     <= RST_BASE_ADDRESS;
            for (int p = 0; p < POOL_COUNT; p++) begin
                bytes_reg[p]   <= RST_BYTES[p];
                count_reg[p]   <= RST_COUNT[p];
                head_reg[p]    <= '0;
                head_ok_reg[p] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr) begin
                case (cfg_index)
                    REG_BASE_ADDRESS: base_reg     <= cfg_data[ADDR_W-1:0];
                    REG_SMALL_BYTES:  bytes_reg[0] <= cfg_data[BYTES_W-1:0];
                    REG_MIDDLE_BYTES: bytes_reg[1] <= cfg_data[BYTES_W-1:0];
                    REG_LARGE_BYTES:  bytes_reg[2] <= cfg_data[BYTES_W-1:0];
                    REG_SMALL_COUNT:  count_reg[0] <= cfg_data[COUNT_W-1:0];
                    REG_MIDDLE_COUNT: count_reg[1] <= cfg_data[COUNT_W-1:0];
                    REG_LARGE_COUNT:  count_reg[2] <= cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (cfg_wr || state_reg != ST_CLEAR) begin
                cnt_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg + LA_W'(1);
            end

            if (state_reg == ST_CLEAR) begin
                for (int p = 0; p < POOL_COUNT; p++) begin
                    head_ok_reg[p] <= (eff[p] != '0);
                    head_reg[p]    <= IDX_W'(ECNT_W'(eff[p] - ECNT_W'(1)));
                end
            end else if (state_reg == ST_POP) begin
                for (int p = 0; p < POOL_COUNT; p++) begin
                    if (pool_reg == POOL_W'(p)) begin
                        head_reg[p]    <= ram_rdata[IDX_W-1:0];
                        head_ok_reg[p] <= ram_rdata[IDX_W];
                    end
                end
            end else if (state_reg == ST_PUSH && rem_reg == '0) begin
                for (int p = 0; p < POOL_COUNT; p++) begin
                    if (pool_reg == POOL_W'(p)) begin
                        head_reg[p]    <= quot_reg[IDX_W-1:0];
                        head_ok_reg[p] <= 1'b1;
                    end
                end
            end

            if (state_reg == ST_RESULT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            for (int p = 0; p < POOL_COUNT; p++) begin
                if (cnt_reg == LA_W'(p)) begin
                    span_reg[p] <= mul_res;
                end
            end
            if (cnt_reg == LA_W'(POOL_COUNT)) begin
                pbase_reg[0] <= base_reg;
            end
            for (int p = 1; p < POOL_COUNT; p++) begin
                if (cnt_reg == LA_W'(POOL_COUNT + p)) begin
                    pbase_reg[p] <= pbase_reg[p-1] + ADDR_W'(span_reg[p-1]);
                end
            end
        end

        if (s_acc) begin
            func_reg  <= s_tuser[0];
            size_reg  <= s_tdata[ADDR_W-1:0];
            raddr_reg <= s_tdata[2*ADDR_W-1:ADDR_W];
        end

        case (state_reg)
            ST_DECODE: begin
                res_addr_reg <= '0;
                if (func_reg == FUNC_ALLOC) begin
                    pool_reg       <= alloc_found ? alloc_pool : '0;
                    res_status_reg <= STS_FALLBACK;
                    for (int p = 0; p < POOL_COUNT; p++) begin
                        if (alloc_pool == POOL_W'(p)) begin
                            idx_reg <= head_reg[p];
                        end
                    end
                end else if (raddr_reg == '0) begin
                    pool_reg       <= '0;
                    res_status_reg <= STS_NULL;
                end else begin
                    pool_reg       <= rel_found ? rel_pool : '0;
                    res_status_reg <= STS_NOT_POOLED;
                    quot_reg       <= SPAN_W'(rel_off_sel);
                    rem_reg        <= '0;
                    dcnt_reg       <= DCNT_W'(SPAN_W - 1);
                end
            end
            ST_POP: begin
                mul_reg <= mul_res;
            end
            ST_ADDR: begin
                res_addr_reg   <= sel_pbase + ADDR_W'(mul_reg);
                res_status_reg <= STS_ALLOCATED;
            end
            ST_DIV: begin
                rem_reg  <= div_ge ? div_diff[BYTES_W-1:0] : div_sh[BYTES_W-1:0];
                quot_reg <= {quot_reg[SPAN_W-2:0], div_ge};
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            end
            ST_PUSH: begin
                if (rem_reg == '0) begin
                    res_status_reg <= STS_RELEASED;
                end else begin
                    pool_reg <= '0;
                end
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_status_reg <= res_status_reg;
                    m_addr_reg   <= res_addr_reg;
                    m_pool_reg   <= pool_reg;
                end
            end
            default: ;
        endcase
    end

    a_pop_from_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DECODE && ram_re |=> sel_head_ok)
        else $error("pop issued on an empty free list");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !ram_re)
        else $error("link RAM read and write in the same cycle");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> div_den != '0)
        else $error("divide by zero block size");

    a_push_sets_head: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PUSH && rem_reg == '0
        |=> sel_head_ok && sel_head == $past(quot_reg[IDX_W-1:0]))
        else $error("push did not update the free-list head");

    a_out_from_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("result shown outside the result state");

endmodule

[tb/size_class_block_pool_allocator_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of size_class_block_pool_allocator_unit: a directed request table
// and random allocate/release traffic over several pool settings, checked against a
// free-list predictor. Depends on scbpa_pkg and the unit under test.
module size_class_block_pool_allocator_unit_tb;
    import scbpa_pkg::*;

    localparam int       MAX_BLOCKS     = 128;
    localparam int       PHASES         = 10;
    localparam int       PHASE_REQUESTS = 140;
    localparam int       SETTLE_CYCLES  = 40;
    localparam int       TIMEOUT_NS     = 10_000_000;
    localparam cfg_idx_t REG_UNUSED     = 3'd7;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   block_address;
        logic [POOL_W-1:0]   pool_index;
    } pool_result_t;

    typedef struct packed {
        logic                func;
        logic [ADDR_W-1:0]   request_size;
        logic [ADDR_W-1:0]   release_address;
        logic                typed;
        pool_result_t        want;
    } table_row_t;

    localparam int DIRECTED_ROWS = 19;
    localparam table_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{FUNC_ALLOC,   32'd0,          32'hFFFF_FFFF, 1'b1, '{STS_ALLOCATED, 32'd4400, 2'd0}},
        '{FUNC_ALLOC,   32'd16,         32'd0,         1'b1, '{STS_ALLOCATED, 32'd4384, 2'd0}},
        '{FUNC_ALLOC,   32'd17,         32'h5555_5555, 1'b1, '{STS_ALLOCATED, 32'd7584, 2'd1}},
        '{FUNC_ALLOC,   32'd64,         32'hAAAA_AAAA, 1'b1, '{STS_ALLOCATED, 32'd8832, 2'd2}},
        '{FUNC_ALLOC,   32'd65,         32'd4400,      1'b1, '{STS_FALLBACK,  32'd0,    2'd0}},
        '{FUNC_ALLOC,   32'hFFFF_FFFF,  32'd0,         1'b1, '{STS_FALLBACK,  32'd0,    2'd0}},
        '{FUNC_RELEASE, 32'hFFFF_FFFF,  32'd0,         1'b1, '{STS_NULL,      32'd0,    2'd0}},
        '{FUNC_RELEASE, 32'd0,          32'd4400,      1'b1, '{STS_RELEASED,  32'd0,    2'd0}},
        '{FUNC_RELEASE, 32'h5555_5555,  32'd4401,      1'b1, '{STS_NOT_POOLED, 32'd0,   2'd0}},
        '{FUNC_RELEASE, 32'hAAAA_AAAA,  32'd4095,      1'b1, '{STS_NOT_POOLED, 32'd0,   2'd0}},
        '{FUNC_RELEASE, 32'd0,          32'hFFFF_FFFF, 1'b1, '{STS_NOT_POOLED, 32'd0,   2'd0}},
        '{FUNC_RELEASE, 32'd0,          32'd7584,      1'b1, '{STS_RELEASED,  32'd0,    2'd1}},
        '{FUNC_RELEASE, 32'd0,          32'd8832,      1'b1, '{STS_RELEASED,  32'd0,    2'd2}},
        '{FUNC_RELEASE, 32'd0,          32'd8896,      1'b1, '{STS_NOT_POOLED, 32'd0,   2'd0}},
        // same block again: no double-free check
        '{FUNC_RELEASE, 32'd0,          32'd8832,      1'b1, '{STS_RELEASED,  32'd0,    2'd2}},
        '{FUNC_ALLOC,   32'd64,         32'd0,         1'b0, '0},
        '{FUNC_ALLOC,   32'd64,         32'd0,         1'b0, '0},
        '{FUNC_RELEASE, 32'd0,          32'd4096,      1'b1, '{STS_RELEASED,  32'd0,    2'd0}},
        '{FUNC_ALLOC,   32'd1,          32'h8000_0000, 1'b0, '0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // pool settings and free lists as the block should hold them
    logic [ADDR_W-1:0]  pool_origin;
    logic [BYTES_W-1:0] block_bytes [POOL_COUNT];
    logic [COUNT_W-1:0] block_count [POOL_COUNT];
    logic [6:0]         head_idx    [POOL_COUNT];
    logic               head_valid  [POOL_COUNT];
    logic [6:0]         next_link   [POOL_COUNT][MAX_BLOCKS];
    logic               link_valid  [POOL_COUNT][MAX_BLOCKS];

    pool_result_t      expected_results [$];
    logic [ADDR_W-1:0] live_blocks      [$];
    logic [ADDR_W-1:0] freed_blocks     [$];
    logic [CFG_DATA_W-1:0] setting_plan [8];

    int failures = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    size_class_block_pool_allocator_unit #(.MAX_BLOCKS(MAX_BLOCKS)) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int eff_blocks(int p);
        if (block_bytes[p] == 0) return 0;
        return (block_count[p] > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count[p]);
    endfunction

    function automatic logic [ADDR_W-1:0] pool_start(int p);
        logic [63:0] acc;
        acc = 64'(pool_origin);
        for (int q = 0; q < p; q++)
            acc += 64'(block_bytes[q]) * 64'(eff_blocks(q));
        return acc[ADDR_W-1:0];
    endfunction

    function automatic void rebuild_free_lists();
        int n;
        for (int p = 0; p < POOL_COUNT; p++) begin
            n = eff_blocks(p);
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                next_link[p][i]  = (i > 0) ? 7'(i - 1) : 7'd0;
                link_valid[p][i] = (i > 0);
            end
            head_valid[p] = (n > 0);
            head_idx[p]   = (n > 0) ? 7'(n - 1) : 7'd0;
        end
        live_blocks.delete();
        freed_blocks.delete();
    endfunction

    function automatic void reset_pools();
        pool_origin = RST_BASE_ADDRESS;
        for (int p = 0; p < POOL_COUNT; p++) begin
            block_bytes[p] = RST_BYTES[p];
            block_count[p] = RST_COUNT[p];
        end
        rebuild_free_lists();
    endfunction

    function automatic void apply_register_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_BASE_ADDRESS: pool_origin = data;
            REG_SMALL_BYTES:  block_bytes[0] = data[BYTES_W-1:0];
            REG_MIDDLE_BYTES: block_bytes[1] = data[BYTES_W-1:0];
            REG_LARGE_BYTES:  block_bytes[2] = data[BYTES_W-1:0];
            REG_SMALL_COUNT:  block_count[0] = data[COUNT_W-1:0];
            REG_MIDDLE_COUNT: block_count[1] = data[COUNT_W-1:0];
            REG_LARGE_COUNT:  block_count[2] = data[COUNT_W-1:0];
            default: return;
        endcase
        rebuild_free_lists();
    endfunction

    function automatic pool_result_t predict_pool_result(logic func, logic [ADDR_W-1:0] size,
                                                         logic [ADDR_W-1:0] addr);
        pool_result_t res;
        logic [6:0]        idx;
        logic [ADDR_W-1:0] off;
        logic [63:0]       span;
        int                n;
        res = '{STS_FALLBACK, '0, '0};
        if (func == FUNC_ALLOC) begin
            for (int p = 0; p < POOL_COUNT; p++) begin
                if (eff_blocks(p) == 0 || size > 32'(block_bytes[p]) || !head_valid[p])
                    continue;
                idx           = head_idx[p];
                head_valid[p] = link_valid[p][idx];
                head_idx[p]   = next_link[p][idx];
                res = '{STS_ALLOCATED, pool_start(p) + 32'(idx) * 32'(block_bytes[p]), POOL_W'(p)};
                break;
            end
        end else if (addr == '0) begin
            res.status = STS_NULL;
        end else begin
            res.status = STS_NOT_POOLED;
            for (int p = 0; p < POOL_COUNT; p++) begin
                n = eff_blocks(p);
                if (n == 0) continue;
                off  = addr - pool_start(p);
                span = 64'(block_bytes[p]) * 64'(n);
                if (64'(off) < span && off % 32'(block_bytes[p]) == 0) begin
                    idx = 7'((off / 32'(block_bytes[p])) % MAX_BLOCKS);
                    next_link[p][idx]  = head_idx[p];
                    link_valid[p][idx] = head_valid[p];
                    head_idx[p]        = idx;
                    head_valid[p]      = 1'b1;
                    res = '{STS_RELEASED, '0, POOL_W'(p)};
                    break;
                end
            end
        end
        return res;
    endfunction

    task automatic send_request(input logic func, input logic [ADDR_W-1:0] size,
                                input logic [ADDR_W-1:0] addr, input logic typed,
                                input pool_result_t typed_want);
        pool_result_t res;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {addr, size};
        do @(posedge aclk); while (!s_tready);
        res = predict_pool_result(func, size, addr);
        if (res.status == STS_ALLOCATED) live_blocks.push_back(res.block_address);
        expected_results.push_back(typed ? typed_want : res);
    endtask

    task automatic issue_random_request();
        int                pick, p, k;
        logic              func;
        logic [ADDR_W-1:0] size, addr;
        func = FUNC_ALLOC;
        size = $urandom;
        addr = $urandom;
        pick = $urandom_range(0, 99);
        if (pick >= 45 && pick < 80 && live_blocks.size() == 0) pick = 0;
        if (pick >= 80 && pick < 86 && freed_blocks.size() == 0) pick = 95;
        p = $urandom_range(0, POOL_COUNT - 1);
        if (pick < 45) begin
            case ($urandom_range(0, 9))
                0:       size = '0;
                1, 2, 3: size = 32'(block_bytes[p]);
                4:       size = 32'(block_bytes[p]) + 1;
                5:       size = 32'(block_bytes[p]) - 1;
                6, 7:    size = $urandom_range(1, 128);
                8:       size = $urandom;
                default: size = 32'hFFFF_FFFF - $urandom_range(0, 3);
            endcase
        end else begin
            func = FUNC_RELEASE;
            if (pick < 80) begin
                k    = $urandom_range(0, live_blocks.size() - 1);
                addr = live_blocks[k];
                live_blocks.delete(k);
                freed_blocks.push_back(addr);
                if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
            end else if (pick < 86) begin
                addr = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
            end else if (pick < 94) begin
                k    = $urandom_range(0, eff_blocks(p) + 1);
                addr = pool_start(p) + 32'(k) * 32'(block_bytes[p]);
                if ($urandom_range(0, 3) == 0) addr += $urandom_range(1, 7);
            end else if (pick < 97) begin
                addr = '0;
            end
        end
        send_request(func, size, addr, 1'b0, '0);
    endtask

    // lower valid and let everything in flight come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register_write(idx, data);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_bytes_setting();
        logic [CFG_DATA_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0:       v[BYTES_W-1:0] = '0;
            1:       v[BYTES_W-1:0] = $urandom_range(0, 1) ? 13'd8191 : 13'd4096;
            default: v[BYTES_W-1:0] = $urandom_range(1, 48);
        endcase
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_count_setting();
        logic [CFG_DATA_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0:       v[COUNT_W-1:0] = '0;
            1:       v[COUNT_W-1:0] = $urandom_range(129, 255);
            2:       v[COUNT_W-1:0] = 8'd128;
            default: v[COUNT_W-1:0] = $urandom_range(1, 6);
        endcase
        return v;
    endfunction

    task automatic fill_setting_plan(input int ph);
        if (ph == 1) begin
            // wrapping pools, widest blocks, counts past the maximum
            setting_plan[REG_BASE_ADDRESS] = 32'hFFFF_FF00;
            setting_plan[REG_SMALL_BYTES]  = 32'd1;
            setting_plan[REG_MIDDLE_BYTES] = 32'd4096;
            setting_plan[REG_LARGE_BYTES]  = 32'd8191;
            setting_plan[REG_SMALL_COUNT]  = 32'd255;
            setting_plan[REG_MIDDLE_COUNT] = 32'd128;
            setting_plan[REG_LARGE_COUNT]  = 32'd129;
        end else if (ph == 2) begin
            // first two pools disabled, last one starts at address zero
            setting_plan[REG_BASE_ADDRESS] = 32'd0;
            setting_plan[REG_SMALL_BYTES]  = 32'd0;
            setting_plan[REG_MIDDLE_BYTES] = 32'd24;
            setting_plan[REG_LARGE_BYTES]  = 32'd7;
            setting_plan[REG_SMALL_COUNT]  = 32'd5;
            setting_plan[REG_MIDDLE_COUNT] = 32'd0;
            setting_plan[REG_LARGE_COUNT]  = 32'd3;
        end else begin
            setting_plan[REG_BASE_ADDRESS] = $urandom_range(0, 7) == 0 ? 32'hFFFF_FFF0 : $urandom;
            setting_plan[REG_SMALL_BYTES]  = pick_bytes_setting();
            setting_plan[REG_MIDDLE_BYTES] = pick_bytes_setting();
            setting_plan[REG_LARGE_BYTES]  = pick_bytes_setting();
            setting_plan[REG_SMALL_COUNT]  = pick_count_setting();
            setting_plan[REG_MIDDLE_COUNT] = pick_count_setting();
            setting_plan[REG_LARGE_COUNT]  = pick_count_setting();
        end
    endtask

    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    always @(posedge aclk) begin
        pool_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d, block_address %0h",
                       m_tuser, m_tdata[ADDR_W-1:0]);
                failures++;
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    failures++;
                end
                if (m_tdata[ADDR_W-1:0] !== want.block_address) begin
                    $error("block_address: expected %0h, got %0h",
                           want.block_address, m_tdata[ADDR_W-1:0]);
                    failures++;
                end
                if (m_tdata[ADDR_W+POOL_W-1:ADDR_W] !== want.pool_index) begin
                    $error("pool_index: expected %0d, got %0d",
                           want.pool_index, m_tdata[ADDR_W+POOL_W-1:ADDR_W]);
                    failures++;
                end
            end
        end
    end

    initial begin
        reset_pools();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
                default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
            endcase
            if (ph == 0) begin
                for (int r = 0; r < DIRECTED_ROWS; r++)
                    send_request(DIRECTED[r].func, DIRECTED[r].request_size,
                                 DIRECTED[r].release_address, DIRECTED[r].typed,
                                 DIRECTED[r].want);
            end else begin
                fill_setting_plan(ph);
                for (cfg_idx_t r = REG_BASE_ADDRESS; r <= REG_LARGE_COUNT; r++)
                    write_register(r, setting_plan[r]);
            end
            for (int n = (ph == 0) ? DIRECTED_ROWS : 0; n < PHASE_REQUESTS; n++) begin
                // unknown index mid-traffic: free lists must survive it
                if (ph % 4 == 1 && n == PHASE_REQUESTS / 2) begin
                    drain();
                    write_register(REG_UNUSED, $urandom);
                end
                issue_random_request();
            end
            drain();
        end
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

[size_class_block_pool_allocator_unit.f]
src/scbpa_pkg.sv
src/scbpa_ram.sv
src/size_class_block_pool_allocator_unit.sv
tb/size_class_block_pool_allocator_unit_tb.sv
